// ===== rtl/core/ttd_pkg.sv =====
// Shared types, constants and helpers for the twiddled texel detwiddler.
// Used by ttd_addr and twiddled_texel_detwiddle; depends on nothing else.
`default_nettype none

package ttd_pkg;

  localparam int MAX_SIDE_LOG2 = 10;
  localparam int SIDE_W = 4;
  localparam int CNT_W = 20;
  localparam int TOT_W = $clog2(2 * MAX_SIDE_LOG2 + 1);
  localparam int TEXEL_W = 16;
  localparam int CHAN_W = 8;
  localparam int OUT_DATA_W = ((CNT_W + 3 * CHAN_W + 7) / 8) * 8;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_LOG2  = 1'b0,
    CFG_HEIGHT_LOG2 = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [SIDE_W-1:0] wl;
    logic [SIDE_W-1:0] hl;
    logic [SIDE_W-1:0] side;
  } geom_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] lim;
    lim = SIDE_W'(MAX_SIDE_LOG2);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [CNT_W-1:0] tex_mask(input logic [TOT_W-1:0] tot);
    logic [CNT_W:0] one;
    logic [CNT_W:0] m;
    one = (CNT_W + 1)'(1);
    m = (one << tot) - one;
    return m[CNT_W-1:0];
  endfunction

  // With both channels scaled by 16, floor(c*a*256/255) equals c*a since c*a <= 225.
  function automatic logic [CHAN_W-1:0] premul(input logic [3:0] c, input logic [3:0] a);
    return {4'b0000, c} * {4'b0000, a};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ttd_addr.sv =====
// Morton decode of a twiddled texel index into a linear texel address.
// Depends on ttd_pkg for the geometry struct and widths.
`default_nettype none

module ttd_addr (
  input  ttd_pkg::geom_t                geom,
  input  logic [ttd_pkg::CNT_W-1:0]     cnt,
  output logic [ttd_pkg::CNT_W-1:0]     address
);
  import ttd_pkg::*;

  logic [2*MAX_SIDE_LOG2-1:0] cnt_pairs;
  logic [MAX_SIDE_LOG2-1:0] xm;
  logic [MAX_SIDE_LOG2-1:0] ym;
  logic [CNT_W-1:0]         blk;
  logic [CNT_W-1:0]         blk_sh;
  logic [CNT_W-1:0]         x;
  logic [CNT_W-1:0]         y;

  assign cnt_pairs = (2 * MAX_SIDE_LOG2)'(cnt);

  always_comb begin
    for (int i = 0; i < MAX_SIDE_LOG2; i++) begin
      xm[i] = (i < int'(geom.side)) && cnt_pairs[2*i+1];
      ym[i] = (i < int'(geom.side)) && cnt_pairs[2*i];
    end
  end

  assign blk    = cnt >> {geom.side, 1'b0};
  assign blk_sh = blk << geom.side;

  always_comb begin
    x = {{(CNT_W-MAX_SIDE_LOG2){1'b0}}, xm};
    y = {{(CNT_W-MAX_SIDE_LOG2){1'b0}}, ym};
    if (geom.wl > geom.hl) begin
      x = x | blk_sh;
    end else if (geom.hl > geom.wl) begin
      y = y | blk_sh;
    end
  end

  assign address = (y << geom.wl) | x;

endmodule

`default_nettype wire

// ===== rtl/core/twiddled_texel_detwiddle.sv =====
// Top level of the twiddled texel detwiddler: counter, input stage, result stage.
// Depends on ttd_pkg and ttd_addr.
//
// Usage: ARGB4444 texels stream in on the in_ channel in twiddled order, one
// beat per texel. Each accepted beat yields exactly one result beat on the
// out_ channel carrying the linear address and the alpha-premultiplied color;
// out_tlast marks the final texel of the texture, after which the internal
// counter wraps to zero. The cfg_ channel sets width_log2 (index 0) and
// height_log2 (index 1); it is always ready and should be written only while
// no texels are in flight.
// Each beat passes through an input register holding texel and index, then a
// result register after the address decode and premultiply logic. Throughput
// is one texel per cycle while the receiver does not stall.
// Reset clears the counter and both stage valids and sets both dimensions to 8.
// When the receiver stalls, the result register holds its beat and the input
// register fills; in_tready drops only when both stages hold beats.
`default_nettype none

module twiddled_texel_detwiddle (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ttd_pkg::TEXEL_W-1:0]       in_tdata,    // [15:0] texel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ttd_pkg::OUT_DATA_W-1:0]    out_tdata,   // [19:0] address, [27:20] red,
                                                         // [35:28] green, [43:36] blue
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ttd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ttd_pkg::SIDE_W-1:0]        cfg_data
);
  import ttd_pkg::*;

  logic [SIDE_W-1:0]     wl_r;
  logic [SIDE_W-1:0]     hl_r;
  logic [CNT_W-1:0]      counter_r;
  logic [CNT_W-1:0]      counter_nxt;
  logic                  a_vld_r;
  logic [TEXEL_W-1:0]    a_texel_r;
  logic [CNT_W-1:0]      a_cnt_r;
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic                  out_last_r;

  geom_t                 geom;
  logic [TOT_W-1:0]      tot_sum;
  logic [TOT_W-1:0]      tot;
  logic [CNT_W-1:0]      tmask;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      address;
  logic                  in_fire;
  logic                  b_adv;
  logic [3:0]            alpha;

  always_comb begin
    geom.wl   = clamp_side(wl_r);
    geom.hl   = clamp_side(hl_r);
    geom.side = (geom.wl < geom.hl) ? geom.wl : geom.hl;
  end

  assign tot_sum     = TOT_W'(geom.wl) + TOT_W'(geom.hl);
  assign tot         = (int'(tot_sum) > CNT_W) ? TOT_W'(CNT_W) : tot_sum;
  assign tmask       = tex_mask(tot);
  assign cnt         = counter_r & tmask;
  assign counter_nxt = (cnt + CNT_W'(1)) & tmask;

  assign b_adv     = !out_vld_r || out_tready;
  assign in_tready = !a_vld_r || b_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= SIDE_W'(3);
      hl_r <= SIDE_W'(3);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH_LOG2:  wl_r <= cfg_data;
        CFG_HEIGHT_LOG2: hl_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
      a_vld_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        counter_r <= counter_nxt;
      end
      if (in_tready) begin
        a_vld_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_texel_r <= in_tdata;
      a_cnt_r   <= cnt;
    end
  end

  ttd_addr u_addr (
    .geom    (geom),
    .cnt     (a_cnt_r),
    .address (address)
  );

  assign alpha = a_texel_r[15:12];

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[CNT_W-1:0]                          = address;
    out_data_nxt[CNT_W +: CHAN_W]                    = premul(a_texel_r[11:8], alpha);
    out_data_nxt[CNT_W+CHAN_W +: CHAN_W]             = premul(a_texel_r[7:4], alpha);
    out_data_nxt[CNT_W+2*CHAN_W +: CHAN_W]           = premul(a_texel_r[3:0], alpha);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (b_adv) begin
      out_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_vld_r) begin
      out_data_r <= out_data_nxt;
      out_last_r <= (a_cnt_r == tmask);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A beat in the input register moves to the output when the output frees up.
  a_moves_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && b_adv) |=> out_tvalid)
    else $error("input stage beat was not moved to the output register");

  // Both stages full with a stalled receiver must block new input.
  full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while pipeline was full and stalled");

  // An accepted beat always lands in the input register.
  fire_fills_a: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> a_vld_r)
    else $error("accepted beat missing from input register");

  // Reset empties both stages.
  reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!a_vld_r && !out_tvalid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== sim/twiddled_texel_detwiddle_test.sv =====
// Self-checking testbench for twiddled_texel_detwiddle: predicts each texel's linear address,
// premultiplied color and end-of-texture flag, and checks every result beat against it.
// Depends on ttd_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module twiddled_texel_detwiddle_test;
  import ttd_pkg::*;

  typedef struct packed {
    logic [19:0] address;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic [TEXEL_W-1:0]    in_tdata = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  cfg_idx_t              cfg_index = CFG_WIDTH_LOG2;
  logic [SIDE_W-1:0]     cfg_data = '0;
  wire                   in_tready;
  wire                   out_tvalid;
  wire [OUT_DATA_W-1:0]  out_tdata;
  wire                   out_tlast;
  wire                   cfg_ready;

  logic [3:0]   width_log2_q = 4'd3;
  logic [3:0]   height_log2_q = 4'd3;
  logic [19:0]  twiddle_index = '0;
  pixel_t       pending_pixels[$];
  int unsigned  texels_sent = 0;
  int unsigned  mismatches = 0;
  int unsigned  stall_left = 0;
  bit           gaps_on = 1'b1;
  bit           stalls_on = 1'b1;

  twiddled_texel_detwiddle dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned side_log2(input logic [3:0] v);
    return (v > MAX_SIDE_LOG2) ? MAX_SIDE_LOG2 : v;
  endfunction

  function automatic logic [7:0] scale_by_alpha(input logic [3:0] c, input logic [3:0] a);
    int unsigned prod;
    prod = ({28'd0, c} << 4) * ({28'd0, a} << 4);
    return 8'(prod / 255);
  endfunction

  // Decodes the current twiddled index under the present geometry and advances it.
  function automatic pixel_t detwiddle_texel(input logic [15:0] texel);
    int unsigned wl, hl, tot, side, i;
    logic [63:0] tmask, idx, inblk, blk, x, y, addr;
    pixel_t px;
    wl = side_log2(width_log2_q);
    hl = side_log2(height_log2_q);
    tot = (wl + hl > 20) ? 20 : wl + hl;
    tmask = (64'd1 << tot) - 64'd1;
    idx = {44'd0, twiddle_index} & tmask;
    side = (wl < hl) ? wl : hl;
    inblk = idx & ((64'd1 << (2 * side)) - 64'd1);
    blk = idx >> (2 * side);
    x = '0;
    y = '0;
    if (wl > hl) x = blk << side;
    else if (hl > wl) y = blk << side;
    for (i = 0; i < side; i++) begin
      x = x + (64'(inblk[2 * i + 1]) << i);
      y = y + (64'(inblk[2 * i]) << i);
    end
    addr = (y << wl) + x;
    px.address = addr[19:0];
    px.red = scale_by_alpha(texel[11:8], texel[15:12]);
    px.green = scale_by_alpha(texel[7:4], texel[15:12]);
    px.blue = scale_by_alpha(texel[3:0], texel[15:12]);
    px.last = (idx == tmask);
    twiddle_index = 20'((idx + 64'd1) & tmask);
    return px;
  endfunction

  always @(posedge clk) begin
    if (!stalls_on) begin
      stall_left = 0;
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_tready <= (stall_left == 0);
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.address = out_tdata[19:0];
      got.red = out_tdata[27:20];
      got.green = out_tdata[35:28];
      got.blue = out_tdata[43:36];
      got.last = out_tlast;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: addr %h rgb %h %h %h last %b",
                   got.address, got.red, got.green, got.blue, got.last);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected addr %h rgb %h %h %h last %b, ",
                      "got addr %h rgb %h %h %h last %b"},
                     want.address, want.red, want.green, want.blue, want.last,
                     got.address, got.red, got.green, got.blue, got.last);
        end
      end
    end
  end

  task automatic send_texel(input logic [15:0] texel);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= texel;
    do @(posedge clk); while (!in_tready);
    pending_pixels.push_back(detwiddle_texel(texel));
    texels_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [3:0] wl, input logic [3:0] hl);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WIDTH_LOG2;
    cfg_data <= wl;
    do @(posedge clk); while (!cfg_ready);
    width_log2_q = wl;
    cfg_index <= CFG_HEIGHT_LOG2;
    cfg_data <= hl;
    do @(posedge clk); while (!cfg_ready);
    height_log2_q = hl;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_texel_extremes();
    logic [15:0] patterns [10] = '{16'h0000, 16'hFFFF, 16'hF000, 16'h0FFF, 16'hFF00,
                                   16'hF0F0, 16'hF00F, 16'h1FFF, 16'h8421, 16'h7ABC};
    foreach (patterns[k]) send_texel(patterns[k]);
  endtask

  // Shrinking the texture leaves the counter past its end, so it must fold back.
  task automatic test_counter_fold();
    set_geometry(4'd1, 4'd1);
    repeat (3) send_texel(16'($urandom_range(0, 65535)));
  endtask

  task automatic test_degenerate_sizes();
    set_geometry(4'd0, 4'd0);
    repeat (2) send_texel(16'($urandom_range(0, 65535)));
    set_geometry(4'd15, 4'd0);
    repeat (2) send_texel(16'($urandom_range(0, 65535)));
    set_geometry(4'd2, 4'd15);
    repeat (2) send_texel(16'($urandom_range(0, 65535)));
    set_geometry(4'd10, 4'd10);
    repeat (2) send_texel(16'($urandom_range(0, 65535)));
  endtask

  task automatic test_random_textures();
    int unsigned wl, hl, tot, size, n;
    while (texels_sent < 1000) begin
      if ($urandom_range(0, 7) == 0) begin
        wl = $urandom_range(0, 15);
        hl = $urandom_range(0, 15);
      end else begin
        wl = $urandom_range(0, 4);
        hl = $urandom_range(0, 4);
      end
      set_geometry(4'(wl), 4'(hl));
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      tot = side_log2(4'(wl)) + side_log2(4'(hl));
      size = 1 << ((tot > 20) ? 20 : tot);
      if (size <= 128 && $urandom_range(0, 1) == 1)
        n = size - (twiddle_index & (size - 1)) + $urandom_range(0, 4);
      else
        n = $urandom_range(1, 80);
      repeat (n) send_texel(16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic test_back_to_back();
    set_geometry(4'd3, 4'd2);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (50) send_texel(16'($urandom_range(0, 65535)));
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_texel_extremes();
    test_counter_fold();
    test_degenerate_sizes();
    test_random_textures();
    test_back_to_back();
    if (mismatches == 0)
      $display("twiddled_texel_detwiddle_test: done, clean");
    else
      $display("twiddled_texel_detwiddle_test: done, errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("twiddled_texel_detwiddle_test: done, errors");
    $finish;
  end

endmodule
